>>> rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the sieve block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

>>> rtl/core/spfs_pkg.sv
// ----------------------------------------------------------------------------
// spfs_pkg
// Types and constants of the smallest prime factor sieve.
// ----------------------------------------------------------------------------
package spfs_pkg;

   localparam int MAX_VALUE   = 65535;
   localparam int TBL_DEPTH   = MAX_VALUE + 1;
   localparam int ADDR_W      = $clog2(TBL_DEPTH);
   localparam int VALUE_W     = 16;
   localparam int FIRST_PRIME = 2;
   localparam int MAX_RESULTS = 6;
   localparam int CNT_W       = $clog2(MAX_RESULTS + 1);
   localparam int DIV_CNT_W   = $clog2(ADDR_W + 1);

   localparam logic FUNC_BUILD = 1'b0;
   localparam logic FUNC_QUERY = 1'b1;

   typedef struct packed {
      logic               func;
      logic [VALUE_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic [VALUE_W-1:0] factor;
      logic               has_factor;
      logic               value_is_prime;
      logic               table_ready;
      logic               last;
   } rsp_type;

   typedef struct packed {
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      logic [ADDR_W-1:0] wr_data;
      logic [ADDR_W-1:0] rd_addr;
   } mem_req_type;

   typedef struct packed {
      logic busy;
      logic done;
   } bld_sts_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_sts_type;

endpackage

>>> rtl/core/spfs_ram.sv
// ----------------------------------------------------------------------------
// spfs_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module spfs_ram #(
   parameter int ADDR_BITS = 16,
   parameter int DATA_BITS = 16
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [DATA_BITS-1:0] wr_data,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [DATA_BITS-1:0] rd_data
);

   logic [DATA_BITS-1:0] mem [2**ADDR_BITS];
   logic [DATA_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/spfs_div.sv
// ----------------------------------------------------------------------------
// spfs_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module spfs_div import spfs_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [ADDR_W-1:0] dividend,
   input  logic [ADDR_W-1:0] divisor,
   output logic [ADDR_W-1:0] quotient,
   output div_sts_type       sts
);

   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [ADDR_W-1:0]    rem_ff, rem_in;
   logic [ADDR_W-1:0]    quo_ff, quo_in;
   logic [ADDR_W-1:0]    dvs_ff, dvs_in;
   logic                 done_ff, done_in;
   logic [ADDR_W:0]      rem_sh;
   logic [ADDR_W:0]      diff;

   always_comb begin
      rem_sh  = {rem_ff, quo_ff[ADDR_W-1]};
      diff    = rem_sh - {1'b0, dvs_ff};
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      done_in = 1'b0;
      if (start) begin
         cnt_in = DIV_CNT_W'(ADDR_W);
         rem_in = '0;
         quo_in = dividend;
         dvs_in = divisor;
      end else if (cnt_ff != '0) begin
         if (!diff[ADDR_W]) begin
            rem_in = diff[ADDR_W-1:0];
            quo_in = {quo_ff[ADDR_W-2:0], 1'b1};
         end else begin
            rem_in = rem_sh[ADDR_W-1:0];
            quo_in = {quo_ff[ADDR_W-2:0], 1'b0};
         end
         cnt_in  = cnt_ff - 1'b1;
         done_in = (cnt_ff == DIV_CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign quotient = quo_ff;
   assign sts.busy = (cnt_ff != '0);
   assign sts.done = done_ff;

endmodule

>>> rtl/core/spfs_build.sv
// ----------------------------------------------------------------------------
// spfs_build
// Sieve sequencer: fills the table with identity, then marks multiples.
// ----------------------------------------------------------------------------
module spfs_build import spfs_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [ADDR_W-1:0] rd_data,
   output mem_req_type       mem_req,
   output bld_sts_type       sts
);

   typedef enum logic [2:0] {B_IDLE, B_INIT, B_CHECK, B_TEST, B_MARK, B_DONE} state_type;

   localparam logic [ADDR_W:0] LIMIT = (ADDR_W+1)'(MAX_VALUE);

   state_type         state_ff, state_in;
   logic [ADDR_W-1:0] addr_ff, addr_in;
   logic [ADDR_W-1:0] i_ff, i_in;
   logic [ADDR_W:0]   sq_ff, sq_in;
   logic [ADDR_W:0]   j_ff, j_in;
   logic              pend_ff, pend_in;
   logic [ADDR_W-1:0] pend_addr_ff, pend_addr_in;
   logic [ADDR_W-1:0] pend_val_ff, pend_val_in;
   logic [ADDR_W:0]   j_nxt;

   always_comb begin
      state_in     = state_ff;
      addr_in      = addr_ff;
      i_in         = i_ff;
      sq_in        = sq_ff;
      j_in         = j_ff;
      pend_in      = 1'b0;
      pend_addr_in = pend_addr_ff;
      pend_val_in  = pend_val_ff;
      j_nxt        = j_ff + {1'b0, i_ff};
      mem_req      = '0;
      mem_req.rd_addr = i_ff;

      // read-modify-write: mark only entries still holding their own index
      if (pend_ff && (rd_data == pend_addr_ff)) begin
         mem_req.wr_en   = 1'b1;
         mem_req.wr_addr = pend_addr_ff;
         mem_req.wr_data = pend_val_ff;
      end

      case (state_ff)
         B_IDLE: begin
            if (start) begin
               addr_in  = '0;
               state_in = B_INIT;
            end
         end
         B_INIT: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = addr_ff;
            mem_req.wr_data = addr_ff;
            if (addr_ff == ADDR_W'(MAX_VALUE)) begin
               i_in     = ADDR_W'(FIRST_PRIME);
               sq_in    = (ADDR_W+1)'(FIRST_PRIME * FIRST_PRIME);
               state_in = B_CHECK;
            end else begin
               addr_in = addr_ff + 1'b1;
            end
         end
         B_CHECK: begin
            if (sq_ff > LIMIT) begin
               state_in = B_DONE;
            end else begin
               state_in = B_TEST;
            end
         end
         B_TEST: begin
            if (rd_data == i_ff) begin
               j_in     = sq_ff;
               state_in = B_MARK;
            end else begin
               sq_in    = sq_ff + {i_ff, 1'b1};
               i_in     = i_ff + 1'b1;
               state_in = B_CHECK;
            end
         end
         B_MARK: begin
            mem_req.rd_addr = j_ff[ADDR_W-1:0];
            pend_in      = 1'b1;
            pend_addr_in = j_ff[ADDR_W-1:0];
            pend_val_in  = i_ff;
            j_in         = j_nxt;
            if (j_nxt > LIMIT) begin
               sq_in    = sq_ff + {i_ff, 1'b1};
               i_in     = i_ff + 1'b1;
               state_in = B_CHECK;
            end
         end
         B_DONE: begin
            state_in = B_IDLE;
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_IDLE;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         pend_ff  <= pend_in;
      end
      addr_ff      <= addr_in;
      i_ff         <= i_in;
      sq_ff        <= sq_in;
      j_ff         <= j_in;
      pend_addr_ff <= pend_addr_in;
      pend_val_ff  <= pend_val_in;
   end

   assign sts.busy = (state_ff != B_IDLE);
   assign sts.done = (state_ff == B_DONE);

endmodule

>>> rtl/core/smallest_prime_factor_sieve.sv
// ----------------------------------------------------------------------------
// smallest_prime_factor_sieve
// Smallest prime factor table with sieve build and factorization queries.
//
//   channel  ports                        payload
//   request  req_valid/req_stall/req_data func, value
//   response rsp_valid/rsp_stall/rsp_data factor, flags, last
//
// Build: an init pass over all MAX_VALUE+1 entries, then a check and a test per
// sieve candidate and one mark per multiple visited; bound by the table port.
// Query: a table read, then a run of the serial divider per prime divided out
// (counted with multiplicity), plus an emit step per distinct factor; other
// items go straight to the response.
// Reset does not clear the table; queries before a build report table not ready.
// A result register lets the next item in while the last result is stalled.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module smallest_prime_factor_sieve import spfs_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   typedef enum logic [2:0] {S_IDLE, S_BUILD, S_FIRST, S_DIV, S_NEXT, S_EMIT} state_type;

   state_type         state_ff, state_in;
   logic              built_ff, built_in;
   logic [ADDR_W-1:0] x_ff, x_in;
   logic [ADDR_W-1:0] p_ff, p_in;
   logic [ADDR_W-1:0] np_ff, np_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              prime_ff, prime_in;
   rsp_type           res_ff, res_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;

   logic              accept;
   logic              out_free;
   logic [ADDR_W-1:0] qry_rd_addr;
   logic              div_start;
   logic [ADDR_W-1:0] div_divisor;
   logic [ADDR_W-1:0] div_quo;
   div_sts_type       div_sts;
   logic              bld_start;
   mem_req_type       bld_req;
   bld_sts_type       bld_sts;
   logic              ram_wr_en;
   logic [ADDR_W-1:0] ram_rd_addr;
   logic [ADDR_W-1:0] rd_data;
   logic              factor_ok;

   spfs_ram #(
      .ADDR_BITS(ADDR_W),
      .DATA_BITS(ADDR_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (bld_req.wr_addr),
      .wr_data (bld_req.wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (rd_data)
   );

   spfs_build u_build (
      .clock   (clock),
      .reset   (reset),
      .start   (bld_start),
      .rd_data (rd_data),
      .mem_req (bld_req),
      .sts     (bld_sts)
   );

   spfs_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (x_ff),
      .divisor  (div_divisor),
      .quotient (div_quo),
      .sts      (div_sts)
   );

   assign req_stall   = (state_ff != S_IDLE);
   assign accept      = req_valid && (state_ff == S_IDLE);
   assign out_free    = !rsp_valid_ff || !rsp_stall;
   assign ram_wr_en   = (state_ff == S_BUILD) && bld_req.wr_en;
   assign ram_rd_addr = (state_ff == S_BUILD) ? bld_req.rd_addr : qry_rd_addr;

   always_comb begin
      state_in     = state_ff;
      built_in     = built_ff;
      x_in         = x_ff;
      p_in         = p_ff;
      np_in        = np_ff;
      cnt_in       = cnt_ff;
      prime_in     = prime_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      qry_rd_addr  = x_ff;
      div_start    = 1'b0;
      div_divisor  = p_ff;
      bld_start    = 1'b0;

      case (state_ff)
         S_IDLE: begin
            qry_rd_addr = ADDR_W'(req_data.value);
            if (accept) begin
               res_in      = '0;
               res_in.last = 1'b1;
               if (req_data.func == FUNC_BUILD) begin
                  bld_start = 1'b1;
                  state_in  = S_BUILD;
               end else if (!built_ff) begin
                  state_in = S_EMIT;
               end else if ((req_data.value < VALUE_W'(FIRST_PRIME)) ||
                            (32'(req_data.value) > MAX_VALUE)) begin
                  res_in.table_ready = 1'b1;
                  state_in           = S_EMIT;
               end else begin
                  x_in     = ADDR_W'(req_data.value);
                  cnt_in   = '0;
                  state_in = S_FIRST;
               end
            end
         end
         S_BUILD: begin
            if (bld_sts.done) begin
               built_in           = 1'b1;
               res_in             = '0;
               res_in.table_ready = 1'b1;
               res_in.last        = 1'b1;
               state_in           = S_EMIT;
            end
         end
         S_FIRST: begin
            p_in        = rd_data;
            prime_in    = (rd_data == x_ff);
            div_start   = 1'b1;
            div_divisor = rd_data;
            state_in    = S_DIV;
         end
         S_DIV: begin
            qry_rd_addr = div_quo;
            if (div_sts.done) begin
               x_in = div_quo;
               if (div_quo == ADDR_W'(1)) begin
                  res_in.factor         = VALUE_W'(p_ff);
                  res_in.has_factor     = 1'b1;
                  res_in.value_is_prime = prime_ff;
                  res_in.table_ready    = 1'b1;
                  res_in.last           = 1'b1;
                  state_in              = S_EMIT;
               end else begin
                  state_in = S_NEXT;
               end
            end
         end
         S_NEXT: begin
            if (rd_data == p_ff) begin
               div_start = 1'b1;
               state_in  = S_DIV;
            end else begin
               np_in                 = rd_data;
               res_in.factor         = VALUE_W'(p_ff);
               res_in.has_factor     = 1'b1;
               res_in.value_is_prime = prime_ff;
               res_in.table_ready    = 1'b1;
               res_in.last           = (cnt_ff == CNT_W'(MAX_RESULTS - 1));
               state_in              = S_EMIT;
            end
         end
         S_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_in       = res_ff;
               cnt_in       = cnt_ff + 1'b1;
               if (res_ff.last) begin
                  state_in = S_IDLE;
               end else begin
                  p_in        = np_ff;
                  div_start   = 1'b1;
                  div_divisor = np_ff;
                  state_in    = S_DIV;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if ((state_ff != S_EMIT || !out_free) && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         built_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         built_ff     <= built_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      x_ff     <= x_in;
      p_ff     <= p_in;
      np_ff    <= np_in;
      cnt_ff   <= cnt_in;
      prime_ff <= prime_in;
      res_ff   <= res_in;
      rsp_ff   <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign factor_ok = rsp_ff.table_ready && (rsp_ff.factor >= VALUE_W'(FIRST_PRIME));

   `ASSERT_IMPLY(a_build_owns_ram, clock, reset, bld_sts.busy, state_ff == S_BUILD)
   `ASSERT_NEXT(a_build_starts, clock, reset, bld_start, bld_sts.busy)
   `ASSERT_IMPLY(a_div_start_idle, clock, reset, div_start, !div_sts.busy)
   `ASSERT_IMPLY(a_factor_sane, clock, reset, rsp_valid_ff && rsp_ff.has_factor, factor_ok)

endmodule
